[design/clnbd_pkg.sv]
// clnbd_pkg: shared types, request codes and init command table for the
// character lcd nibble bus driver. No dependencies.
`timescale 1ns / 1ps

package clnbd_pkg;

  localparam int MaxSnaps  = 7;
  localparam int SnapIdxW  = $clog2(MaxSnaps);
  localparam int InitLen   = 5;

  localparam logic [2:0] REQ_CMD    = 3'd0;
  localparam logic [2:0] REQ_DATA   = 3'd1;
  localparam logic [2:0] REQ_CURSOR = 3'd2;
  localparam logic [2:0] REQ_BUSY   = 3'd3;
  localparam logic [2:0] REQ_TICK   = 3'd4;
  localparam logic [2:0] REQ_START  = 3'd5;

  localparam logic [7:0] CURSOR_FLAG = 8'h80;

  typedef struct packed {
    logic       en;
    logic       rs;
    logic       rw;
    logic [3:0] nib;
    logic       inp;
    logic       rdy;
    logic       rej;
  } snap_t;

  function automatic snap_t mk_snap(logic en, logic rs, logic rw, logic [3:0] nib,
                                    logic inp, logic rdy, logic rej);
    snap_t s;
    s.en  = en;
    s.rs  = rs;
    s.rw  = rw;
    s.nib = inp ? 4'd0 : nib;
    s.inp = inp;
    s.rdy = rdy;
    s.rej = rej;
    return s;
  endfunction

  function automatic logic [7:0] init_cmd(logic [2:0] step);
    logic [7:0] c;
    case (step)
      3'd0:    c = 8'h02;
      3'd1:    c = 8'h28;
      3'd2:    c = 8'h0C;
      3'd3:    c = 8'h01;
      3'd4:    c = 8'h06;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[design/clnbd_req_if.sv]
// clnbd_req_if: request channel (valid/ready plus request fields).
// Depends on nothing.
`timescale 1ns / 1ps

interface clnbd_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] byte_value;
  logic       busy_pin;

  modport source (output valid, req_type, byte_value, busy_pin, input ready);
  modport sink   (input valid, req_type, byte_value, busy_pin, output ready);
endinterface

[design/clnbd_pin_if.sv]
// clnbd_pin_if: pin snapshot channel (valid/ready plus snapshot fields).
// Depends on nothing.
`timescale 1ns / 1ps

interface clnbd_pin_if;
  logic       valid;
  logic       ready;
  logic       enable_pin;
  logic       reg_select;
  logic       read_write;
  logic [3:0] data_nibble;
  logic       bus_is_input;
  logic       ready_res;
  logic       rejected;
  logic       last_item;

  modport source (output valid, enable_pin, reg_select, read_write, data_nibble,
                  bus_is_input, ready_res, rejected, last_item, input ready);
  modport sink   (input valid, enable_pin, reg_select, read_write, data_nibble,
                  bus_is_input, ready_res, rejected, last_item, output ready);
endinterface

[design/char_lcd_nibble_bus_driver_top.sv]
// char_lcd_nibble_bus_driver_top: hd44780-style 4-bit bus driver, one module.
// Depends on clnbd_pkg, clnbd_req_if and clnbd_pin_if.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   req_type, byte_value, busy_pin
//   pins     out  valid/ready   one pin snapshot per beat
//   cfg      in   cfg_we        cfg_index, cfg_data (write only)
//
// a request is decoded in its accept cycle into a burst of 0..7 snapshots held
// in the snapshot buffer, sent one beat per cycle while the pin channel is
// ready; the next item is taken in the cycle the final beat leaves, so
// throughput is set by the single output beat per cycle. items with no
// snapshot leave the buffer empty. rst is synchronous and returns the
// controller to idle with the buffer empty. output stalls hold the burst.
`timescale 1ns / 1ps

module char_lcd_nibble_bus_driver_top
  import clnbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  clnbd_req_if.sink   req,
  clnbd_pin_if.source pins,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [1:0] {PH_IDLE, PH_INIT, PH_POLL} phase_t;

  phase_t     phase, phase_next;
  logic [2:0] init_step, init_step_next;
  logic [7:0] wait_count, wait_count_next;
  logic       select_level, select_level_next;
  logic [3:0] nibble_level, nibble_level_next;
  logic [7:0] power_up_wait_ticks;
  logic [7:0] init_step_wait_ticks;

  snap_t             snaps [MaxSnaps];
  snap_t             snaps_next [MaxSnaps];
  logic [SnapIdxW-1:0] snap_cnt, snap_cnt_next;
  logic [SnapIdxW-1:0] snap_idx;
  logic                buf_valid;

  logic       in_fire, out_fire, last_beat;
  logic [7:0] wbyte;
  logic [7:0] wc_dec;
  logic       do_write;
  logic       write_sel;

  assign last_beat = snap_idx == (snap_cnt - SnapIdxW'(1));
  assign out_fire  = pins.valid && pins.ready;
  assign req.ready = !buf_valid || (out_fire && last_beat);
  assign in_fire   = req.valid && req.ready;

  assign pins.valid        = buf_valid;
  assign pins.enable_pin   = snaps[snap_idx].en;
  assign pins.reg_select   = snaps[snap_idx].rs;
  assign pins.read_write   = snaps[snap_idx].rw;
  assign pins.data_nibble  = snaps[snap_idx].nib;
  assign pins.bus_is_input = snaps[snap_idx].inp;
  assign pins.ready_res    = snaps[snap_idx].rdy;
  assign pins.rejected     = snaps[snap_idx].rej;
  assign pins.last_item    = last_beat;

  assign wc_dec = (wait_count != 8'd0) ? wait_count - 8'd1 : wait_count;

  always_comb begin
    phase_next        = phase;
    init_step_next    = init_step;
    wait_count_next   = wait_count;
    select_level_next = select_level;
    nibble_level_next = nibble_level;
    snap_cnt_next     = '0;
    do_write          = 1'b0;
    write_sel         = 1'b0;
    wbyte             = req.byte_value;
    for (int k = 0; k < MaxSnaps; k++) begin
      snaps_next[k] = '0;
    end

    case (req.req_type) inside
      REQ_CMD, REQ_DATA, REQ_CURSOR, REQ_START: begin
        if (phase != PH_IDLE) begin
          // refused: present pin levels, state untouched
          if (phase == PH_POLL) begin
            snaps_next[0] = mk_snap(1'b0, 1'b0, 1'b1, 4'd0, 1'b1, 1'b0, 1'b1);
          end else begin
            snaps_next[0] = mk_snap(1'b0, select_level, 1'b0, nibble_level,
                                    1'b0, 1'b0, 1'b1);
          end
          snap_cnt_next = SnapIdxW'(1);
        end else if (req.req_type == REQ_START) begin
          phase_next        = PH_INIT;
          init_step_next    = 3'd0;
          wait_count_next   = power_up_wait_ticks;
          select_level_next = 1'b0;
          snaps_next[0] = mk_snap(1'b0, 1'b0, 1'b0, nibble_level, 1'b0, 1'b0, 1'b0);
          snap_cnt_next = SnapIdxW'(1);
        end else begin
          do_write  = 1'b1;
          write_sel = req.req_type == REQ_DATA;
          wbyte     = (req.req_type == REQ_CURSOR) ? (req.byte_value | CURSOR_FLAG)
                                                   : req.byte_value;
          // busy poll opens straight after the byte
          snaps_next[6]     = mk_snap(1'b0, 1'b0, 1'b1, 4'd0, 1'b1, 1'b0, 1'b0);
          snap_cnt_next     = SnapIdxW'(7);
          phase_next        = PH_POLL;
          select_level_next = 1'b0;
        end
      end
      REQ_BUSY: begin
        if (phase == PH_POLL) begin
          snaps_next[0] = mk_snap(1'b1, 1'b0, 1'b1, 4'd0, 1'b1, 1'b0, 1'b0);
          snaps_next[1] = mk_snap(1'b0, 1'b0, 1'b1, 4'd0, 1'b1, 1'b0, 1'b0);
          snaps_next[2] = mk_snap(1'b1, 1'b0, 1'b1, 4'd0, 1'b1, 1'b0, 1'b0);
          snaps_next[3] = mk_snap(1'b0, 1'b0, 1'b1, 4'd0, 1'b1, 1'b0, 1'b0);
          snap_cnt_next = SnapIdxW'(4);
          if (!req.busy_pin) begin
            phase_next    = PH_IDLE;
            snaps_next[4] = mk_snap(1'b0, 1'b0, 1'b0, nibble_level, 1'b0, 1'b1, 1'b0);
            snap_cnt_next = SnapIdxW'(5);
          end
        end
      end
      REQ_TICK: begin
        if (phase == PH_INIT) begin
          wait_count_next = wc_dec;
          if (wc_dec == 8'd0) begin
            if (init_step < 3'(InitLen)) begin
              do_write          = 1'b1;
              write_sel         = 1'b0;
              select_level_next = 1'b0;
              wbyte             = init_cmd(init_step);
              init_step_next    = init_step + 3'd1;
              wait_count_next   = init_step_wait_ticks;
              snap_cnt_next     = SnapIdxW'(6);
            end else begin
              phase_next        = PH_POLL;
              select_level_next = 1'b0;
              snaps_next[0] = mk_snap(1'b0, 1'b0, 1'b1, 4'd0, 1'b1, 1'b0, 1'b0);
              snap_cnt_next = SnapIdxW'(1);
            end
          end
        end
      end
      default: ;
    endcase

    if (do_write) begin
      // high nibble then low nibble: strobe up with bus clear, place, strobe down
      snaps_next[0] = mk_snap(1'b1, write_sel, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0);
      snaps_next[1] = mk_snap(1'b1, write_sel, 1'b0, wbyte[7:4], 1'b0, 1'b0, 1'b0);
      snaps_next[2] = mk_snap(1'b0, write_sel, 1'b0, wbyte[7:4], 1'b0, 1'b0, 1'b0);
      snaps_next[3] = mk_snap(1'b1, write_sel, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0);
      snaps_next[4] = mk_snap(1'b1, write_sel, 1'b0, wbyte[3:0], 1'b0, 1'b0, 1'b0);
      snaps_next[5] = mk_snap(1'b0, write_sel, 1'b0, wbyte[3:0], 1'b0, 1'b0, 1'b0);
      nibble_level_next = wbyte[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_IDLE;
      init_step            <= 3'd0;
      wait_count           <= 8'd0;
      select_level         <= 1'b0;
      nibble_level         <= 4'd0;
      power_up_wait_ticks  <= 8'd30;
      init_step_wait_ticks <= 8'd1;
      buf_valid            <= 1'b0;
      snap_cnt             <= '0;
      snap_idx             <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'b0) begin
          power_up_wait_ticks <= cfg_data;
        end else begin
          init_step_wait_ticks <= cfg_data;
        end
      end
      if (in_fire) begin
        phase        <= phase_next;
        init_step    <= init_step_next;
        wait_count   <= wait_count_next;
        select_level <= select_level_next;
        nibble_level <= nibble_level_next;
        snaps        <= snaps_next;
        snap_cnt     <= snap_cnt_next;
        snap_idx     <= '0;
        buf_valid    <= snap_cnt_next != '0;
      end else if (out_fire) begin
        if (last_beat) begin
          buf_valid <= 1'b0;
        end else begin
          snap_idx <= snap_idx + SnapIdxW'(1);
        end
      end
    end
  end

endmodule

[tb/sv/tb_char_lcd_nibble_bus_driver_top.sv]
// tb_char_lcd_nibble_bus_driver_top: self-checking bench for the lcd nibble bus driver.
// Predicts pin snapshots per request beat and checks them in order on the pin channel.
// Depends on clnbd_pkg, clnbd_req_if, clnbd_pin_if and char_lcd_nibble_bus_driver_top.
`timescale 1ns / 1ps

module tb_char_lcd_nibble_bus_driver_top;
  import clnbd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_PRINTED = 40;

  localparam logic CFG_POWER_UP_WAIT = 1'b0;
  localparam logic CFG_STEP_WAIT     = 1'b1;

  // init commands, first one in the low byte
  localparam logic [39:0] INIT_SEQ = {8'h06, 8'h01, 8'h0C, 8'h28, 8'h02};

  typedef enum logic [1:0] {LCD_IDLE, LCD_STARTUP, LCD_POLL} lcd_phase_t;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] value;
    logic       busy;
  } lcd_req_t;

  typedef struct packed {
    snap_t pin;
    logic  last;
  } lcd_beat_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [7:0] cfg_data;

  clnbd_req_if req_ch ();
  clnbd_pin_if pin_ch ();

  char_lcd_nibble_bus_driver_top dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .pins      (pin_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lcd_req_t  pending_reqs[$];
  lcd_req_t  in_flight;
  lcd_beat_t expected_beats[$];

  int queued_items;
  int accepted_items;
  int active_items;
  int beat_count;
  int mismatches;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;

  // predicted controller state and register copies
  lcd_phase_t lcd_state;
  logic [2:0] init_idx;
  logic [7:0] ticks_left;
  logic       rs_level;
  logic [3:0] nib_level;
  logic [7:0] power_up_wait;
  logic [7:0] step_wait;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_char_lcd_nibble_bus_driver_top NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("mismatch at beat %0d: %s", beat_count, msg);
  endtask

  task automatic push_snap(logic en, logic rs, logic rw, logic [3:0] nib, logic inp,
                           logic rdy, logic rej);
    lcd_beat_t b;
    b.pin.en  = en;
    b.pin.rs  = rs;
    b.pin.rw  = rw;
    b.pin.nib = inp ? 4'h0 : nib;
    b.pin.inp = inp;
    b.pin.rdy = rdy;
    b.pin.rej = rej;
    b.last    = 1'b0;
    expected_beats.push_back(b);
  endtask

  task automatic push_present(logic rej);
    if (lcd_state == LCD_POLL) push_snap(1'b0, 1'b0, 1'b1, 4'h0, 1'b1, 1'b0, rej);
    else push_snap(1'b0, rs_level, 1'b0, nib_level, 1'b0, 1'b0, rej);
  endtask

  task automatic send_byte(logic [7:0] b);
    push_snap(1'b1, rs_level, 1'b0, 4'h0,   1'b0, 1'b0, 1'b0);
    push_snap(1'b1, rs_level, 1'b0, b[7:4], 1'b0, 1'b0, 1'b0);
    push_snap(1'b0, rs_level, 1'b0, b[7:4], 1'b0, 1'b0, 1'b0);
    push_snap(1'b1, rs_level, 1'b0, 4'h0,   1'b0, 1'b0, 1'b0);
    push_snap(1'b1, rs_level, 1'b0, b[3:0], 1'b0, 1'b0, 1'b0);
    push_snap(1'b0, rs_level, 1'b0, b[3:0], 1'b0, 1'b0, 1'b0);
    nib_level = b[3:0];
  endtask

  task automatic enter_poll();
    rs_level  = 1'b0;
    lcd_state = LCD_POLL;
    push_snap(1'b0, 1'b0, 1'b1, 4'h0, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic predict_snapshots(lcd_req_t r);
    int n0;
    n0 = expected_beats.size();
    case (r.kind)
      REQ_CMD, REQ_DATA, REQ_CURSOR, REQ_START: begin
        if (lcd_state != LCD_IDLE) begin
          push_present(1'b1);
        end else if (r.kind == REQ_START) begin
          lcd_state  = LCD_STARTUP;
          init_idx   = 3'd0;
          ticks_left = power_up_wait;
          rs_level   = 1'b0;
          push_present(1'b0);
        end else begin
          rs_level = (r.kind == REQ_DATA);
          send_byte(r.kind == REQ_CURSOR ? (r.value | CURSOR_FLAG) : r.value);
          enter_poll();
        end
      end
      REQ_BUSY: begin
        if (lcd_state == LCD_POLL) begin
          // two enable pulses, the second read is a dummy
          push_snap(1'b1, 1'b0, 1'b1, 4'h0, 1'b1, 1'b0, 1'b0);
          push_snap(1'b0, 1'b0, 1'b1, 4'h0, 1'b1, 1'b0, 1'b0);
          push_snap(1'b1, 1'b0, 1'b1, 4'h0, 1'b1, 1'b0, 1'b0);
          push_snap(1'b0, 1'b0, 1'b1, 4'h0, 1'b1, 1'b0, 1'b0);
          if (!r.busy) begin
            lcd_state = LCD_IDLE;
            push_snap(1'b0, 1'b0, 1'b0, nib_level, 1'b0, 1'b1, 1'b0);
          end
        end
      end
      REQ_TICK: begin
        if (lcd_state == LCD_STARTUP) begin
          if (ticks_left != 8'd0) ticks_left--;
          if (ticks_left == 8'd0) begin
            if (init_idx < InitLen) begin
              rs_level = 1'b0;
              send_byte(INIT_SEQ[init_idx*8 +: 8]);
              init_idx++;
              ticks_left = step_wait;
            end else begin
              enter_poll();
            end
          end
        end
      end
      default: ;
    endcase
    if (expected_beats.size() > n0) expected_beats[expected_beats.size()-1].last = 1'b1;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_CMD;
      req_ch.byte_value <= 8'h00;
      req_ch.busy_pin   <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_snapshots(in_flight);
        accepted_items++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = pending_reqs.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.req_type   <= in_flight.kind;
          req_ch.byte_value <= in_flight.value;
          req_ch.busy_pin   <= in_flight.busy;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_bit(string name, logic got, logic want);
    if (got !== want) report_mismatch($sformatf("%s got %0b want %0b", name, got, want));
  endtask

  // pin snapshot monitor
  always @(posedge clk) begin
    if (rst) begin
      pin_ch.ready <= 1'b0;
    end else begin
      if (pin_ch.valid && pin_ch.ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("snapshot beat with nothing expected");
        end else begin
          check_bit("enable_pin",     pin_ch.enable_pin,   expected_beats[0].pin.en);
          check_bit("reg_select",     pin_ch.reg_select,   expected_beats[0].pin.rs);
          check_bit("read_write",     pin_ch.read_write,   expected_beats[0].pin.rw);
          check_field("data_nibble",  pin_ch.data_nibble,  expected_beats[0].pin.nib);
          check_bit("bus_is_input",   pin_ch.bus_is_input, expected_beats[0].pin.inp);
          check_bit("ready_res",      pin_ch.ready_res,    expected_beats[0].pin.rdy);
          check_bit("rejected",       pin_ch.rejected,     expected_beats[0].pin.rej);
          check_bit("last_item",      pin_ch.last_item,    expected_beats[0].last);
          void'(expected_beats.pop_front());
        end
        beat_count++;
      end
      pin_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_req(logic [2:0] kind, logic [7:0] value, logic busy);
    lcd_req_t r;
    r.kind  = kind;
    r.value = value;
    r.busy  = busy;
    pending_reqs.push_back(r);
    queued_items++;
    active_items++;
  endtask

  // an item that the given controller phase refuses or ignores
  task automatic queue_noise(lcd_phase_t ctx);
    lcd_req_t r;
    logic     ok;
    ok = 1'b0;
    while (!ok) begin
      r.kind = 3'($urandom_range(0, 7));
      case (ctx)
        LCD_IDLE:    ok = r.kind inside {REQ_BUSY, REQ_TICK} || r.kind > REQ_START;
        LCD_STARTUP: ok = r.kind != REQ_TICK;
        default:     ok = r.kind != REQ_BUSY;
      endcase
    end
    r.value = 8'($urandom_range(0, 255));
    r.busy  = 1'($urandom_range(0, 1));
    pending_reqs.push_back(r);
    queued_items++;
  endtask

  task automatic queue_poll();
    int n;
    n = $urandom_range(0, 3);
    repeat (n) begin
      if ($urandom_range(99) < 25) queue_noise(LCD_POLL);
      queue_req(REQ_BUSY, 8'($urandom_range(0, 255)), 1'b1);
    end
    if ($urandom_range(99) < 20) queue_noise(LCD_POLL);
    queue_req(REQ_BUSY, 8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic queue_write();
    queue_req(3'($urandom_range(0, 2)), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    queue_poll();
  endtask

  function automatic int init_ticks();
    int p;
    int s;
    p = (power_up_wait == 8'd0) ? 1 : int'(power_up_wait);
    s = (step_wait == 8'd0) ? 1 : int'(step_wait);
    return p + InitLen * s;
  endfunction

  task automatic queue_init();
    int n;
    n = init_ticks();
    queue_req(REQ_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    repeat (n) begin
      if ($urandom_range(99) < 10) queue_noise(LCD_STARTUP);
      queue_req(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    queue_poll();
  endtask

  task automatic queue_random(int count);
    int r;
    int n0;
    n0 = active_items;
    while (active_items - n0 < count) begin
      r = $urandom_range(99);
      if (r < 80) queue_write();
      else if (r < 90 && init_ticks() <= 40) queue_init();
      else queue_noise(LCD_IDLE);
    end
  endtask

  task automatic wait_quiet();
    while (accepted_items != queued_items || expected_beats.size() != 0) @(posedge clk);
    // ignored items leave no beat behind, give them time to clear
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POWER_UP_WAIT) power_up_wait = value;
    else step_wait = value;
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = 1'b0;
    cfg_data          = 8'h00;
    lcd_state         = LCD_IDLE;
    init_idx          = 3'd0;
    ticks_left        = 8'd0;
    rs_level          = 1'b0;
    nib_level         = 4'h0;
    power_up_wait     = 8'd30;
    step_wait         = 8'd1;
    send_idle_pct     = 36;
    recv_idle_pct     = 48;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: byte extremes, rejects during a poll, ignored items while idle
    queue_req(REQ_CMD, 8'h00, 1'b0);
    queue_req(REQ_BUSY, 8'h00, 1'b1);
    queue_req(REQ_CMD, 8'h5A, 1'b0);
    queue_req(REQ_START, 8'h00, 1'b0);
    queue_req(REQ_TICK, 8'h00, 1'b0);
    queue_req(3'd6, 8'hFF, 1'b1);
    queue_req(3'd7, 8'h00, 1'b0);
    queue_req(REQ_BUSY, 8'hFF, 1'b0);
    queue_req(REQ_BUSY, 8'h00, 1'b0);
    queue_req(REQ_TICK, 8'hFF, 1'b1);
    queue_req(REQ_DATA, 8'hFF, 1'b1);
    queue_req(REQ_BUSY, 8'h00, 1'b0);
    queue_req(REQ_CURSOR, 8'h00, 1'b0);
    queue_req(REQ_BUSY, 8'h00, 1'b0);
    queue_req(REQ_CURSOR, 8'hFF, 1'b0);
    queue_req(REQ_BUSY, 8'h00, 1'b0);
    queue_req(REQ_CURSOR, 8'h7F, 1'b0);
    queue_req(REQ_BUSY, 8'h00, 1'b0);
    queue_req(REQ_DATA, 8'h00, 1'b0);
    queue_req(REQ_BUSY, 8'h00, 1'b1);
    queue_req(REQ_BUSY, 8'h00, 1'b0);
    queue_req(REQ_CMD, 8'hFF, 1'b0);
    queue_req(REQ_BUSY, 8'h00, 1'b0);
    queue_req(REQ_DATA, 8'hA5, 1'b0);
    queue_req(REQ_BUSY, 8'h00, 1'b0);
    // init at the reset wait values
    queue_init();
    queue_random(60);
    wait_quiet();

    write_cfg(CFG_POWER_UP_WAIT, 8'd0);
    write_cfg(CFG_STEP_WAIT, 8'd0);
    queue_init();
    queue_random(50);
    wait_quiet();

    send_idle_pct = 48;
    recv_idle_pct = 36;
    write_cfg(CFG_POWER_UP_WAIT, 8'd12);
    write_cfg(CFG_STEP_WAIT, 8'd3);
    queue_init();
    queue_random(35);
    wait_quiet();

    write_cfg(CFG_POWER_UP_WAIT, 8'd3);
    write_cfg(CFG_STEP_WAIT, 8'd2);
    queue_random(45);
    wait_quiet();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cfg(CFG_POWER_UP_WAIT, 8'd1);
    write_cfg(CFG_STEP_WAIT, 8'd0);
    queue_init();
    queue_random(45);
    wait_quiet();

    if (mismatches == 0) begin
      $display("tb_char_lcd_nibble_bus_driver_top OK");
    end else begin
      $display("tb_char_lcd_nibble_bus_driver_top NOT OK");
    end
    $finish;
  end

endmodule
